// ===== rtl/qfd_pkg.sv =====
// Package for the quadtree fill decoder: sizes, region and result types,
// and the error codes. No dependencies; used by rtl/quadtree_fill_decoder.sv.
package qfd_pkg;

  // Largest image side (log2) and the number of regions the queue can hold.
  localparam int unsigned MAX_SIDE_LOG2 = 10;
  localparam int unsigned QUEUE_DEPTH   = 4096;

  // Widths of the coordinate and side fields.
  localparam int unsigned CoordW = MAX_SIDE_LOG2;
  localparam int unsigned SideW  = 4;
  localparam int unsigned ColorW = 8;

  // Queue pointer and occupancy widths.
  localparam int unsigned QPtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCntW  = $clog2(QUEUE_DEPTH + 1);

  // Image side after reset.
  localparam logic [SideW-1:0] SideReset = SideW'(9);

  typedef enum logic [1:0] {
    ErrNone      = 2'd0,
    ErrOverflow  = 2'd1,
    ErrSideOne   = 2'd2,
    ErrAfterDone = 2'd3
  } err_e;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
    logic [SideW-1:0]  side;
  } region_t;

  localparam int unsigned EntryW = $bits(region_t);

  typedef struct packed {
    region_t           region;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
    logic              done;
    err_e              err;
  } result_t;

endpackage

// ===== rtl/qfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// A read at the address being written returns the old contents. No dependencies.
module qfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/quadtree_fill_decoder.sv =====
// Top level of the quadtree fill decoder: region tracking, region queue
// control and output buffering. Depends on rtl/qfd_pkg.sv and rtl/qfd_ram.sv.
//
// The block takes the nodes of a quadtree in breadth-first order on the input
// channel (in_valid_i / in_stall_o) and gives one fill request per leaf, plus
// one error request for a dropped internal node or a node after the tree is
// done, on the output channel (out_valid_o / out_stall_i). The first node
// covers the whole image; each later node is the next quadrant of the current
// parent, in the order top-left, top-right, bottom-right, bottom-left.
// Throughput is one node per cycle while in_stall_o is low: each node does at
// most one push into and one pop from the region queue, and the head of the
// queue is kept prefetched from the queue memory, read every cycle at the next
// head address. A request is registered before it appears on the outputs.
// The output side has an output register and one skid register, so a stall
// from the receiver only reaches in_stall_o after two requests are held.
// The image side is set by a write on the configuration channel, which is
// always ready; any write restarts decoding at the root. The user must make
// writes only while no request is outstanding; the block does not enforce it.
// Reset restores side 9 and an empty queue; only written entries are read.
module quadtree_fill_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration channel.
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [qfd_pkg::SideW-1:0]    cfg_image_side_log2_i,
  // Node channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         node_is_leaf_i,
  input  logic [qfd_pkg::ColorW-1:0]   node_red_i,
  input  logic [qfd_pkg::ColorW-1:0]   node_green_i,
  input  logic [qfd_pkg::ColorW-1:0]   node_blue_i,
  // Fill request channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [qfd_pkg::CoordW-1:0]   fill_row_o,
  output logic [qfd_pkg::CoordW-1:0]   fill_col_o,
  output logic [qfd_pkg::SideW-1:0]    fill_side_log2_o,
  output logic [qfd_pkg::ColorW-1:0]   fill_red_o,
  output logic [qfd_pkg::ColorW-1:0]   fill_green_o,
  output logic [qfd_pkg::ColorW-1:0]   fill_blue_o,
  output logic                         tree_complete_o,
  output logic [1:0]                   error_kind_o
);

  localparam logic [qfd_pkg::QCntW-1:0] QFull = qfd_pkg::QCntW'(qfd_pkg::QUEUE_DEPTH);
  localparam logic [qfd_pkg::QPtrW-1:0] QLast = qfd_pkg::QPtrW'(qfd_pkg::QUEUE_DEPTH - 1);

  // Decoder state.
  logic [qfd_pkg::SideW-1:0]  side_cfg_q, side_cfg_d;
  logic [qfd_pkg::QPtrW-1:0]  head_q, head_d, tail_q, tail_d;
  logic [qfd_pkg::QCntW-1:0]  fill_q, fill_d;
  qfd_pkg::region_t           parent_q, parent_d;
  logic [1:0]                 slot_q, slot_d;
  logic                       root_seen_q, root_seen_d;
  logic                       finished_q, finished_d;

  // Forwarding of a write that hits the address being read.
  logic                       fwd_q, fwd_d;
  qfd_pkg::region_t           fwd_data_q;

  // Output register and skid register.
  qfd_pkg::result_t           out_q, out_d, skid_q, skid_d;
  logic                       out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  // Per-node datapath.
  logic                       accept;
  logic                       out_ready;
  qfd_pkg::region_t           region;
  qfd_pkg::region_t           head_ent;
  logic [qfd_pkg::SideW-1:0]  child_side;
  logic [qfd_pkg::CoordW-1:0] half;
  logic                       need_parent;
  logic                       push;
  logic                       pop;
  qfd_pkg::result_t           res;
  logic                       res_valid;

  logic                          ram_we;
  logic [qfd_pkg::EntryW-1:0]    ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !skid_valid_q;
  assign in_stall_o  = skid_valid_q;
  assign out_ready   = !out_valid_q || !out_stall_i;

  // The head of the queue is the last read of the memory unless that entry
  // was written in the same cycle as the read.
  assign head_ent = fwd_q ? fwd_data_q : qfd_pkg::region_t'(ram_rdata);

  always_comb begin
    side_cfg_d  = side_cfg_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fill_d      = fill_q;
    parent_d    = parent_q;
    slot_d      = slot_q;
    root_seen_d = root_seen_q;
    finished_d  = finished_q;
    need_parent = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    res         = '0;
    res_valid   = 1'b0;

    child_side = (parent_q.side != '0) ? parent_q.side - qfd_pkg::SideW'(1) : '0;
    half       = (parent_q.side != '0) ? (qfd_pkg::CoordW'(1) << child_side) : '0;

    // Region of the current node.
    if (!root_seen_q) begin
      region.row  = '0;
      region.col  = '0;
      region.side = side_cfg_q;
      need_parent = 1'b1;
    end else begin
      region.side = child_side;
      region.row  = (slot_q == 2'd2 || slot_q == 2'd3) ? parent_q.row + half : parent_q.row;
      region.col  = (slot_q == 2'd1 || slot_q == 2'd2) ? parent_q.col + half : parent_q.col;
      need_parent = (slot_q == 2'd3);
    end

    if (accept) begin
      res_valid = 1'b1;
      if (finished_q) begin
        res.err = qfd_pkg::ErrAfterDone;
      end else begin
        root_seen_d = 1'b1;
        if (root_seen_q) begin
          slot_d = slot_q + 2'd1;
        end
        res.region = region;
        res.err    = qfd_pkg::ErrNone;
        if (node_is_leaf_i) begin
          res.red   = node_red_i;
          res.green = node_green_i;
          res.blue  = node_blue_i;
        end else if (region.side == '0) begin
          res.err = qfd_pkg::ErrSideOne;
        end else if (fill_q >= QFull) begin
          res.err = qfd_pkg::ErrOverflow;
        end else begin
          push      = 1'b1;
          res_valid = 1'b0;
        end

        if (need_parent) begin
          if (fill_q != '0) begin
            pop      = 1'b1;
            parent_d = head_ent;
            slot_d   = 2'd0;
          end else if (push) begin
            // The queue was empty: the region just queued becomes the parent.
            pop      = 1'b1;
            parent_d = region;
            slot_d   = 2'd0;
          end else begin
            finished_d = 1'b1;
            res.done   = 1'b1;
          end
        end

        if (push) begin
          tail_d = (tail_q == QLast) ? '0 : tail_q + qfd_pkg::QPtrW'(1);
        end
        if (pop) begin
          head_d = (head_q == QLast) ? '0 : head_q + qfd_pkg::QPtrW'(1);
        end
        fill_d = fill_q + qfd_pkg::QCntW'(push) - qfd_pkg::QCntW'(pop);
      end
    end

    // A configuration write restarts decoding at the root.
    if (cfg_valid_i) begin
      side_cfg_d  = (cfg_image_side_log2_i > qfd_pkg::SideW'(qfd_pkg::MAX_SIDE_LOG2)) ?
                    qfd_pkg::SideW'(qfd_pkg::MAX_SIDE_LOG2) : cfg_image_side_log2_i;
      head_d      = '0;
      tail_d      = '0;
      fill_d      = '0;
      parent_d    = '0;
      slot_d      = '0;
      root_seen_d = 1'b0;
      finished_d  = 1'b0;
    end
  end

  assign ram_we = push;
  assign fwd_d  = ram_we && (tail_q == head_d);

  qfd_ram #(
    .WIDTH (qfd_pkg::EntryW),
    .DEPTH (qfd_pkg::QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (region),
    .raddr_i (head_d),
    .rdata_o (ram_rdata)
  );

  // Output register with one skid entry behind it.
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_ready) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (out_ready) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cfg_q   <= qfd_pkg::SideReset;
      head_q       <= '0;
      tail_q       <= '0;
      fill_q       <= '0;
      parent_q     <= '0;
      slot_q       <= '0;
      root_seen_q  <= 1'b0;
      finished_q   <= 1'b0;
      fwd_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      side_cfg_q   <= side_cfg_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      fill_q       <= fill_d;
      parent_q     <= parent_d;
      slot_q       <= slot_d;
      root_seen_q  <= root_seen_d;
      finished_q   <= finished_d;
      fwd_q        <= fwd_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= region;
    out_q      <= out_d;
    skid_q     <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign fill_row_o       = out_q.region.row;
  assign fill_col_o       = out_q.region.col;
  assign fill_side_log2_o = out_q.region.side;
  assign fill_red_o       = out_q.red;
  assign fill_green_o     = out_q.green;
  assign fill_blue_o      = out_q.blue;
  assign tree_complete_o  = out_q.done;
  assign error_kind_o     = out_q.err;

  // The queue never holds more regions than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= QFull)
    else $error("region queue occupancy beyond its depth");

  // An empty or a full queue has its head and tail at the same entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0 || fill_q == QFull) |-> head_q == tail_q)
    else $error("queue pointers disagree with occupancy");

  // A held skid entry always sits behind a held output entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid register holds a request ahead of the output register");

  // Once the tree is done nothing more is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni) finished_q |-> !ram_we)
    else $error("region queued after the tree was complete");

  // A node that needs a parent with nothing pending finishes the tree.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !finished_q && need_parent && fill_q == '0 && !push && !cfg_valid_i)
      |=> finished_q)
    else $error("tree not marked complete with no region pending");

endmodule

// ===== dv/quadtree_fill_decoder_tb.sv =====
// Self-checking testbench for quadtree_fill_decoder: a directed table and random trees at
// many image sides, checked against a built-in predictor or typed table expectations.
// Depends on rtl/qfd_pkg.sv and rtl/quadtree_fill_decoder.sv.
`timescale 1ns / 100ps

module quadtree_fill_decoder_tb;

  localparam int unsigned RandomNodes = 850;
  // Drain allowance for the block to go quiet: a request waits in the output or
  // skid register, and two can sit in the output registers at once.
  localparam int unsigned DrainCycles = 4;
  localparam longint unsigned TimeoutNs = 64'd800_000 * 8;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [qfd_pkg::SideW-1:0]   cfg_side = '0;
  logic                        node_valid = 1'b0;
  logic                        node_stall;
  logic                        node_leaf = 1'b0;
  logic [qfd_pkg::ColorW-1:0]  node_red = '0;
  logic [qfd_pkg::ColorW-1:0]  node_green = '0;
  logic [qfd_pkg::ColorW-1:0]  node_blue = '0;
  logic                        fill_valid;
  logic                        fill_stall = 1'b0;
  logic [qfd_pkg::CoordW-1:0]  fill_row;
  logic [qfd_pkg::CoordW-1:0]  fill_col;
  logic [qfd_pkg::SideW-1:0]   fill_side;
  logic [qfd_pkg::ColorW-1:0]  fill_red;
  logic [qfd_pkg::ColorW-1:0]  fill_green;
  logic [qfd_pkg::ColorW-1:0]  fill_blue;
  logic                        fill_done;
  logic [1:0]                  fill_err;

  quadtree_fill_decoder dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .cfg_valid_i           (cfg_valid),
    .cfg_ready_o           (cfg_ready),
    .cfg_image_side_log2_i (cfg_side),
    .in_valid_i            (node_valid),
    .in_stall_o            (node_stall),
    .node_is_leaf_i        (node_leaf),
    .node_red_i            (node_red),
    .node_green_i          (node_green),
    .node_blue_i           (node_blue),
    .out_valid_o           (fill_valid),
    .out_stall_i           (fill_stall),
    .fill_row_o            (fill_row),
    .fill_col_o            (fill_col),
    .fill_side_log2_o      (fill_side),
    .fill_red_o            (fill_red),
    .fill_green_o          (fill_green),
    .fill_blue_o           (fill_blue),
    .tree_complete_o       (fill_done),
    .error_kind_o          (fill_err)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder predictor. It tracks the same things the block does: the queue of
  // internal-node regions still waiting for their children, the current
  // parent and which of its four quadrants comes next.
  // ---------------------------------------------------------------------------
  qfd_pkg::region_t            pending_q[$];
  logic [qfd_pkg::CoordW-1:0]  parent_row;
  logic [qfd_pkg::CoordW-1:0]  parent_col;
  logic [qfd_pkg::SideW-1:0]   parent_side;
  logic [qfd_pkg::SideW-1:0]   image_side;
  logic [1:0]                  quadrant;
  bit                          root_taken;
  bit                          tree_finished;

  // Fill requests predicted and not yet seen on the output channel.
  qfd_pkg::result_t            fill_q[$];

  // Sets the image side (saturating at the largest side) and restarts at the root.
  function automatic void restart_decode(logic [qfd_pkg::SideW-1:0] side);
    image_side    = (side > qfd_pkg::MAX_SIDE_LOG2) ?
                    qfd_pkg::SideW'(qfd_pkg::MAX_SIDE_LOG2) : side;
    pending_q     = {};
    parent_row    = '0;
    parent_col    = '0;
    parent_side   = '0;
    quadrant      = '0;
    root_taken    = 1'b0;
    tree_finished = 1'b0;
  endfunction

  // Places one node of the tree and returns 1 when it yields a fill request.
  function automatic bit place_node(input bit leaf, input logic [qfd_pkg::ColorW-1:0] red,
                                    input logic [qfd_pkg::ColorW-1:0] green,
                                    input logic [qfd_pkg::ColorW-1:0] blue,
                                    output qfd_pkg::result_t res);
    qfd_pkg::region_t            area;
    qfd_pkg::region_t            next_parent;
    logic [qfd_pkg::SideW-1:0]   child_side;
    logic [qfd_pkg::CoordW-1:0]  half;
    bit                          next_needed;
    qfd_pkg::err_e               err;
    bit                          done;

    res = '0;
    // Once the tree is done every node is refused with a request that is zero but for its error.
    if (tree_finished) begin
      res.err = qfd_pkg::ErrAfterDone;
      return 1'b1;
    end
    next_needed = 1'b0;
    err         = qfd_pkg::ErrNone;
    done        = 1'b0;

    if (!root_taken) begin
      area.row    = '0;
      area.col    = '0;
      area.side   = image_side;
      root_taken  = 1'b1;
      next_needed = 1'b1;
    end else begin
      child_side = (parent_side > 0) ? parent_side - 1'b1 : '0;
      half       = (parent_side > 0) ? qfd_pkg::CoordW'(1) << child_side : '0;
      area.row   = parent_row;
      area.col   = parent_col;
      area.side  = child_side;
      // Quadrant order: top-left, top-right, bottom-right, bottom-left.
      if (quadrant == 2'd1 || quadrant == 2'd2) area.col = area.col + half;
      if (quadrant == 2'd2 || quadrant == 2'd3) area.row = area.row + half;
      quadrant = quadrant + 2'd1;
      if (quadrant == 2'd0) next_needed = 1'b1;
    end

    if (!leaf) begin
      if (area.side == 0) begin
        err = qfd_pkg::ErrSideOne;
      end else if (pending_q.size() >= qfd_pkg::QUEUE_DEPTH) begin
        err = qfd_pkg::ErrOverflow;
      end else begin
        pending_q.push_back(area);
      end
    end

    // The pop happens after this node's own push, so an internal node can be
    // its own next parent.
    if (next_needed) begin
      if (pending_q.size() == 0) begin
        tree_finished = 1'b1;
        done          = 1'b1;
      end else begin
        next_parent = pending_q.pop_front();
        parent_row  = next_parent.row;
        parent_col  = next_parent.col;
        parent_side = next_parent.side;
        quadrant    = '0;
      end
    end

    if (!leaf && err == qfd_pkg::ErrNone) return 1'b0;
    res.region = area;
    res.done   = done;
    res.err    = err;
    if (leaf) begin
      res.red   = red;
      res.green = green;
      res.blue  = blue;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall per request, checked at the rising edge.
  // ---------------------------------------------------------------------------
  bit burst_in  = 1'b0;  // sender idles never while set
  bit burst_out = 1'b0;  // receiver stalls never while set
  int stall_left = 0;
  int mismatches = 0;
  int fills_checked = 0;
  int trees_done = 0;
  int kind_seen[4] = '{default: 0};

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    fill_stall = (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  always @(posedge clk) begin : fill_monitor
    qfd_pkg::result_t want;
    if (rst_n && fill_valid && !fill_stall) begin
      if (fill_q.size() == 0) begin
        $error("fill request at row %0d col %0d with none expected", fill_row, fill_col);
        mismatches++;
      end else begin
        want = fill_q.pop_front();
        check_field("fill_row", want.region.row, fill_row);
        check_field("fill_col", want.region.col, fill_col);
        check_field("fill_side_log2", want.region.side, fill_side);
        check_field("fill_red", want.red, fill_red);
        check_field("fill_green", want.green, fill_green);
        check_field("fill_blue", want.blue, fill_blue);
        check_field("tree_complete", want.done, fill_done);
        check_field("error_kind", want.err, fill_err);
        fills_checked++;
        if (fill_done === 1'b1) trees_done++;
        if (!$isunknown(fill_err)) kind_seen[fill_err]++;
      end
      stall_left = burst_out ? 0 : $urandom_range(5);
    end
  end

  // ---------------------------------------------------------------------------
  // Input side.
  // ---------------------------------------------------------------------------
  int nodes_sent = 0;
  int sides_written = 0;

  function automatic logic [qfd_pkg::ColorW-1:0] rand_color();
    return qfd_pkg::ColorW'($urandom_range(255));
  endfunction

  // Offers one node after a random gap and predicts it once accepted. A typed
  // expectation, where given, replaces the predicted request. Called and
  // returning at a falling edge; valid stays high so that a node that follows
  // at once keeps it up.
  task automatic send_node(input bit leaf, input logic [qfd_pkg::ColorW-1:0] red,
                           input logic [qfd_pkg::ColorW-1:0] green,
                           input logic [qfd_pkg::ColorW-1:0] blue,
                           input bit typed, input qfd_pkg::result_t typed_res);
    int               gap;
    bit               has_fill;
    qfd_pkg::result_t res;
    gap = burst_in ? 0 : $urandom_range(5);
    if (gap > 0) begin
      node_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    node_valid = 1'b1;
    node_leaf  = leaf;
    node_red   = red;
    node_green = green;
    node_blue  = blue;
    do @(posedge clk); while (node_stall);
    has_fill = place_node(leaf, red, green, blue, res);
    if (typed) begin
      has_fill = 1'b1;
      res      = typed_res;
    end
    if (has_fill) fill_q.push_back(res);
    nodes_sent++;
    @(negedge clk);
  endtask

  // Holds the sender until every predicted request has come out, then lets
  // extra cycles pass for a trailing internal node that yields nothing.
  task automatic drain_fills(input int extra);
    node_valid = 1'b0;
    while (fill_q.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Writes the image side while the block is idle; this restarts decoding.
  task automatic write_side(input logic [qfd_pkg::SideW-1:0] side);
    drain_fills(DrainCycles);
    cfg_valid = 1'b1;
    cfg_side  = side;
    do @(posedge clk); while (!cfg_ready);
    restart_decode(side);
    sides_written++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed table. Rows with a typed expectation are the ones that can be
  // read straight off the decoding rules; the rest go through the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit                         cfg_wr;
    logic [qfd_pkg::SideW-1:0]  cfg_val;
    bit                         leaf;
    logic [23:0]                rgb;
    bit                         typed;
    qfd_pkg::result_t           want;
  } node_row_t;

  node_row_t node_table[$];

  function automatic void add_row(bit cfg_wr, logic [qfd_pkg::SideW-1:0] cfg_val, bit leaf,
                                  logic [23:0] rgb, bit typed,
                                  logic [qfd_pkg::CoordW-1:0] row,
                                  logic [qfd_pkg::CoordW-1:0] col,
                                  logic [qfd_pkg::SideW-1:0] side,
                                  bit done, qfd_pkg::err_e err);
    node_row_t r;
    r.cfg_wr          = cfg_wr;
    r.cfg_val         = cfg_val;
    r.leaf            = leaf;
    r.rgb             = rgb;
    r.typed           = typed;
    r.want            = '0;
    r.want.region.row = row;
    r.want.region.col = col;
    r.want.region.side = side;
    r.want.done       = done;
    r.want.err        = err;
    if (leaf && err == qfd_pkg::ErrNone) {r.want.red, r.want.green, r.want.blue} = rgb;
    node_table.push_back(r);
  endfunction

  initial begin : stimulus
    int                         phase_len;
    int                         leaf_pct;
    int                         random_nodes;
    bit                         paused_once;
    logic [qfd_pkg::SideW-1:0]  side;

    // Reset state: side 9, root leaf finishes the tree at once.
    add_row(0, 0,  1, 24'hFF00FF, 1, 0, 0, 9, 1, qfd_pkg::ErrNone);
    // Anything after completion is refused with zero fields.
    add_row(0, 0,  0, 24'h123456, 1, 0, 0, 0, 0, qfd_pkg::ErrAfterDone);
    add_row(0, 0,  1, 24'hFFFFFF, 1, 0, 0, 0, 0, qfd_pkg::ErrAfterDone);
    // Side 0: a one-pixel image, as a leaf and as an internal root.
    add_row(1, 0,  1, 24'h00FF00, 1, 0, 0, 0, 1, qfd_pkg::ErrNone);
    add_row(1, 0,  0, 24'hABCDEF, 1, 0, 0, 0, 1, qfd_pkg::ErrSideOne);
    // Sides above the maximum saturate.
    add_row(1, 11, 1, 24'h0000FF, 1, 0, 0, 10, 1, qfd_pkg::ErrNone);
    // Full-size image, two levels, one internal quadrant.
    add_row(1, 15, 0, 24'hFFFFFF, 0, 0, 0, 0, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  1, 24'h000000, 1, 0, 0, 9, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  1, 24'hFFFFFF, 1, 0, 512, 9, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  0, 24'h00FF00, 0, 0, 0, 0, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  1, 24'hA55A3C, 1, 512, 0, 9, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  1, 24'h5AA5C3, 0, 0, 0, 0, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  1, 24'h80FF01, 0, 0, 0, 0, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  1, 24'h7F0080, 0, 0, 0, 0, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  1, 24'h010203, 1, 768, 512, 8, 1, qfd_pkg::ErrNone);
    // Side 1: internal children of one pixel are refused; the last one
    // also empties the queue and reports completion with its error.
    add_row(1, 1,  0, 24'hFFFFFF, 0, 0, 0, 0, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  0, 24'hFFFFFF, 1, 0, 0, 0, 0, qfd_pkg::ErrSideOne);
    add_row(0, 0,  1, 24'h3C3C3C, 0, 0, 0, 0, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  1, 24'hC3C3C3, 0, 0, 0, 0, 0, qfd_pkg::ErrNone);
    add_row(0, 0,  0, 24'h0F0F0F, 1, 1, 0, 0, 1, qfd_pkg::ErrSideOne);
    add_row(0, 0,  1, 24'hF0F0F0, 1, 0, 0, 0, 0, qfd_pkg::ErrAfterDone);
    add_row(1, 10, 1, 24'h00FFFF, 1, 0, 0, 10, 1, qfd_pkg::ErrNone);

    random_nodes = 0;
    paused_once  = 1'b0;
    restart_decode(qfd_pkg::SideReset);
    stall_left = $urandom_range(5);

    // Reset held low from the start, released at a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (node_table[i]) begin
      if (node_table[i].cfg_wr) write_side(node_table[i].cfg_val);
      send_node(node_table[i].leaf, node_table[i].rgb[23:16], node_table[i].rgb[15:8],
                node_table[i].rgb[7:0], node_table[i].typed, node_table[i].want);
    end

    // Random trees. Each phase picks a side (mostly small ones so trees close),
    // a leaf density and a length; a tree cut short is a broken stream, and a
    // few nodes after a finished tree are noise.
    while (random_nodes < RandomNodes) begin
      case ($urandom_range(9))
        0:       side = qfd_pkg::SideW'($urandom_range(15, 11));
        1, 2:    side = qfd_pkg::SideW'($urandom_range(10, 7));
        default: side = qfd_pkg::SideW'($urandom_range(6, 0));
      endcase
      write_side(side);
      burst_in  = ($urandom_range(3) == 0);
      burst_out = ($urandom_range(3) == 0);
      leaf_pct  = $urandom_range(85, 30);
      phase_len = $urandom_range(70, 6);
      for (int n = 0; n < phase_len && !tree_finished; n++) begin
        // Now and then the sender waits until the output side is empty.
        if ((!paused_once && n == 3) || $urandom_range(39) == 0) begin
          drain_fills(0);
          paused_once = 1'b1;
        end
        send_node($urandom_range(99) < leaf_pct, rand_color(), rand_color(),
                  rand_color(), 1'b0, '0);
        random_nodes++;
      end
      if (tree_finished) begin
        repeat ($urandom_range(3)) begin
          send_node(1'($urandom_range(1)), rand_color(), rand_color(), rand_color(),
                    1'b0, '0);
          random_nodes++;
        end
      end
    end

    drain_fills(DrainCycles * 2);

    $display("Sent %0d nodes under %0d side writes; checked %0d fill requests, %0d trees done.",
             nodes_sent, sides_written, fills_checked, trees_done);
    $display("Errors seen: one-pixel internal %0d, after completion %0d.",
             kind_seen[qfd_pkg::ErrSideOne], kind_seen[qfd_pkg::ErrAfterDone]);
    if (mismatches == 0) begin
      $display("quadtree_fill_decoder: match");
    end else begin
      $display("quadtree_fill_decoder: mismatch");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin : watchdog
    #(TimeoutNs);
    $display("Timed out with %0d fill requests outstanding.", fill_q.size());
    $display("quadtree_fill_decoder: mismatch");
    $finish;
  end

endmodule
